[src/nms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_pkg: shared types and constants
// Sizes, operation codes and controller commands for the nearest marked
// node search block.
// ----------------------------------------------------------------------------
package nms_pkg;

	localparam int NODES       = 64;
	localparam int LENGTH_BITS = 16;
	localparam int NODE_W      = $clog2(NODES);
	localparam int ADDR_W      = 2 * NODE_W;
	localparam int DIST_W      = LENGTH_BITS + NODE_W;
	localparam int DEPTH       = NODES * NODES;

	// Operation codes of an input word.
	localparam logic [1:0] OP_ADD_EDGE = 2'd0;
	localparam logic [1:0] OP_SET_BEDS = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;   // write one edge row entry to zero (clearing pass)
		logic latch_in;   // capture the input word
		logic edge_rd;    // read the mirrored edge entry (update phase)
		logic edge_wr;    // write min length at latched address
		logic edge_wr2;   // write the mirrored entry
		logic mark_wr;    // write the bed mark
		logic q_init;     // start a query: clear settled bits, set source
		logic scan_step;  // examine one node in the minimum scan
		logic scan_start; // reset the minimum tracker
		logic settle;     // settle the selected node
		logic relax_rd;   // issue edge read for the relax sweep
		logic res_load;   // load the result register
	} nms_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic scan_last;
		logic relax_last;
		logic min_valid;
		logic min_marked;
	} nms_stat_t;

endpackage

[src/nms_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_ram: generic simple dual-port RAM
// One write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module nms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/nms_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_datapath: edge memory, marks, distances and the search datapath
// Executes controller commands one step at a time.
// ----------------------------------------------------------------------------
module nms_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nms_pkg::nms_cmd_t             cmd,
	output nms_pkg::nms_stat_t            stat,
	input  logic [1:0]                    in_op,
	input  logic [nms_pkg::NODE_W-1:0]    in_a,
	input  logic [nms_pkg::NODE_W-1:0]    in_b,
	input  logic [15:0]                   in_len,
	input  logic [15:0]                   in_beds,
	output logic [1:0]                    op_q_out,
	output logic                          res_found,
	output logic [nms_pkg::NODE_W-1:0]    res_node
);

	localparam int NW = nms_pkg::NODE_W;
	localparam int DW = nms_pkg::DIST_W;
	localparam int LW = nms_pkg::LENGTH_BITS;

	logic [1:0]    op_q;
	logic [NW-1:0] a_q, b_q;
	logic [LW-1:0] len_q;
	logic [15:0]   beds_q;
	logic [nms_pkg::ADDR_W:0] clr_q;
	logic [NW-1:0] idx_q, idx_s1;
	logic          rd_s1;
	logic          scan_s1;
	logic [NW-1:0] min_node_q;
	logic [DW-1:0] min_dist_q;
	logic          min_valid_q;
	logic [nms_pkg::NODES-1:0] bed_q, settled_q, reach_q;
	logic          found_q;
	logic [NW-1:0] node_q;

	logic                      ram_we;
	logic [nms_pkg::ADDR_W-1:0] ram_addr;
	logic [LW-1:0]             ram_wdata, ram_rdata;
	logic [DW:0]               cand;
	logic                      do_wr;
	logic                      relax_hit;
	logic                      dist_we;
	logic [NW-1:0]             dist_waddr;
	logic [DW-1:0]             dist_wdata, dist_rdata;

	// Edge memory access selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = {a_q, b_q};
		ram_wdata = len_q;
		do_wr     = (len_q != '0) && ((ram_rdata == '0) || (len_q < ram_rdata));
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q[nms_pkg::ADDR_W-1:0];
			ram_wdata = '0;
		end else if (cmd.edge_wr) begin
			ram_we = do_wr;
		end else if (cmd.edge_wr2) begin
			ram_we   = do_wr;
			ram_addr = {b_q, a_q};
		end else if (cmd.edge_rd) begin
			ram_addr = {b_q, a_q};
		end else if (cmd.relax_rd) begin
			ram_addr = {min_node_q, idx_q};
		end
	end

	nms_ram #(.WIDTH(LW), .DEPTH(nms_pkg::DEPTH)) u_edge_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(ram_wdata),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q   <= in_op;
			a_q    <= in_a;
			b_q    <= in_b;
			len_q  <= in_len;
			beds_q <= in_beds;
		end
	end

	// Clearing pass counter, scan index and read-stage pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			idx_q   <= '0;
			rd_s1   <= 1'b0;
			scan_s1 <= 1'b0;
			idx_s1  <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			rd_s1   <= cmd.relax_rd;
			scan_s1 <= cmd.scan_step;
			idx_s1  <= idx_q;
			if (cmd.scan_start || cmd.settle) begin
				idx_q <= '0;
			end else if (cmd.scan_step || cmd.relax_rd) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign cand = {1'b0, min_dist_q} + {{(DW + 1 - LW){1'b0}}, ram_rdata};

	// A relax read improves the path to an unsettled neighbor.
	assign relax_hit = rd_s1 && ram_rdata != '0 && !settled_q[idx_s1] &&
	                   (!reach_q[idx_s1] || cand[DW-1:0] < dist_rdata);

	// Marks, settled bits, reachability, minimum tracker and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bed_q       <= '0;
			settled_q   <= '0;
			reach_q     <= '0;
			min_valid_q <= 1'b0;
			min_node_q  <= '0;
			min_dist_q  <= '0;
			found_q     <= 1'b0;
			node_q      <= '0;
		end else begin
			if (cmd.mark_wr) begin
				bed_q[a_q] <= (beds_q != 16'd0);
			end
			if (cmd.q_init) begin
				settled_q <= '0;
				reach_q   <= {{(nms_pkg::NODES - 1){1'b0}}, 1'b1} << a_q;
			end
			if (cmd.scan_start) begin
				min_valid_q <= 1'b0;
			end else if (scan_s1) begin
				if (!settled_q[idx_s1] && reach_q[idx_s1] &&
				    (!min_valid_q || dist_rdata < min_dist_q)) begin
					min_valid_q <= 1'b1;
					min_node_q  <= idx_s1;
					min_dist_q  <= dist_rdata;
				end
			end
			if (cmd.settle) begin
				settled_q[min_node_q] <= 1'b1;
			end
			if (relax_hit) begin
				reach_q[idx_s1] <= 1'b1;
			end
			if (cmd.res_load) begin
				found_q <= min_valid_q && bed_q[min_node_q];
				node_q  <= (min_valid_q && bed_q[min_node_q]) ? min_node_q : '0;
			end
		end
	end

	// Distance memory, written by the source init and the relax sweep and
	// read at the scan or relax index.
	always_comb begin
		dist_we    = cmd.q_init || relax_hit;
		dist_waddr = idx_s1;
		dist_wdata = cand[DW-1:0];
		if (cmd.q_init) begin
			dist_waddr = a_q;
			dist_wdata = '0;
		end
	end

	nms_ram #(.WIDTH(DW), .DEPTH(nms_pkg::NODES)) u_dist_ram (
		.clk  (clk),
		.we   (dist_we),
		.waddr(dist_waddr),
		.wdata(dist_wdata),
		.raddr(idx_q),
		.rdata(dist_rdata)
	);

	assign stat.clr_done   = clr_q[nms_pkg::ADDR_W];
	assign stat.scan_last  = (idx_q == NW'(nms_pkg::NODES - 1));
	assign stat.relax_last = (idx_q == NW'(nms_pkg::NODES - 1));
	assign stat.min_valid  = min_valid_q;
	assign stat.min_marked = bed_q[min_node_q];
	assign op_q_out  = op_q;
	assign res_found = found_q;
	assign res_node  = node_q;

endmodule

[src/nms_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_ctrl: operation sequencer
// Clears the edge memory after reset, then runs updates and searches.
// ----------------------------------------------------------------------------
module nms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic [1:0]          op,
	input  nms_pkg::nms_stat_t  stat,
	output nms_pkg::nms_cmd_t   cmd
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_ERD   = 4'd3;
	localparam logic [3:0] S_EWR   = 4'd4;
	localparam logic [3:0] S_ERD2  = 4'd5;
	localparam logic [3:0] S_EWR2  = 4'd6;
	localparam logic [3:0] S_SCAN  = 4'd7;
	localparam logic [3:0] S_PICK  = 4'd8;
	localparam logic [3:0] S_RELAX = 4'd9;
	localparam logic [3:0] S_DRAIN = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;
	localparam logic [3:0] S_SSTART = 4'd12;
	localparam logic [3:0] S_SDRAIN = 4'd13;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DEC;
				end
			end
			S_DEC: begin
				case (op)
					nms_pkg::OP_ADD_EDGE: state_d = S_ERD;
					nms_pkg::OP_SET_BEDS: begin
						cmd.mark_wr = 1'b1;
						state_d     = S_IDLE;
					end
					nms_pkg::OP_QUERY: begin
						cmd.q_init = 1'b1;
						state_d    = S_SSTART;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ERD: state_d = S_EWR;
			S_EWR: begin
				cmd.edge_wr = 1'b1;
				state_d     = S_ERD2;
			end
			S_ERD2: begin
				cmd.edge_rd = 1'b1;
				state_d     = S_EWR2;
			end
			S_EWR2: begin
				cmd.edge_wr2 = 1'b1;
				state_d      = S_IDLE;
			end
			S_SSTART: begin
				cmd.scan_start = 1'b1;
				state_d        = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_SDRAIN;
				end
			end
			// The last distance read of the scan is compared here.
			S_SDRAIN: state_d = S_PICK;
			S_PICK: begin
				if (!stat.min_valid || stat.min_marked) begin
					cmd.res_load = 1'b1;
					state_d      = S_OUT;
				end else begin
					cmd.settle = 1'b1;
					state_d    = S_RELAX;
				end
			end
			S_RELAX: begin
				cmd.relax_rd = 1'b1;
				if (stat.relax_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_SSTART;
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[src/nearest_marked_node_search_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_marked_node_search_core: nearest marked node search
// Graph store with per-node marks and a Dijkstra search for the closest
// marked node from a source.
// ----------------------------------------------------------------------------
// After reset the block clears its 4096-entry edge memory, one entry per
// cycle, and then raises s_tready. A query settles one node per round; each
// round is a minimum scan over the distance memory, a pick step and a sweep
// of the settled node's edge row through the edge memory port. A final scan
// and pick, which finds a marked node or none, gives the query's result.
module nearest_marked_node_search_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: op[1:0], node_a[7:2], node_b[13:8], edge_length[29:14],
	// free_beds[45:30], zero fill [47:46]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: found[0], nearest_node[6:1], zero fill [7]
	output logic [7:0]  m_tdata
);

	nms_pkg::nms_cmd_t  cmd;
	nms_pkg::nms_stat_t stat;
	logic [1:0]         op_q;
	logic               res_found;
	logic [nms_pkg::NODE_W-1:0] res_node;

	nms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.op       (op_q),
		.stat     (stat),
		.cmd      (cmd)
	);

	nms_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_op    (s_tdata[1:0]),
		.in_a     (s_tdata[7:2]),
		.in_b     (s_tdata[13:8]),
		.in_len   (s_tdata[29:14]),
		.in_beds  (s_tdata[45:30]),
		.op_q_out (op_q),
		.res_found(res_found),
		.res_node (res_node)
	);

	assign m_tdata = {1'b0, res_node, res_found};

endmodule

[src/nms_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_checker: port-level checks
// Observes the stream ports of the search core over time.
// ----------------------------------------------------------------------------
module nms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// A result word holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// The block never takes input while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while result pending");

	// A not-found result carries node zero.
	a_zero_node: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[7:1] == 7'd0)
		else $error("node id nonzero without a hit");

	// An accepted word drops ready in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after accept");

endmodule

bind nearest_marked_node_search_core nms_checker u_nms_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

[verif/nms_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_checker: prediction and comparison for the nearest marked node search
// Watches both stream channels. Accepted edge and mark words update a private
// copy of the graph and marks; each query word yields an expected result,
// and every output word is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module nms_tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	output int          mismatches,
	output int          pending,
	output int          results_seen
);

	typedef struct packed {
		logic                      found;
		logic [nms_pkg::NODE_W-1:0] node;
	} nearest_t;

	logic [nms_pkg::LENGTH_BITS-1:0] road_len [nms_pkg::NODES][nms_pkg::NODES];
	logic                            has_beds [nms_pkg::NODES];
	nearest_t                        nearest_q[$];

	// Dijkstra from src; stops at the first settled node that has beds.
	function automatic nearest_t find_nearest(logic [nms_pkg::NODE_W-1:0] src);
		longint   path_len [nms_pkg::NODES];
		bit       done [nms_pkg::NODES];
		longint   best;
		int       u;
		nearest_t r;
		r = '0;
		foreach (path_len[i]) begin
			path_len[i] = -1;
			done[i] = 0;
		end
		path_len[src] = 0;
		for (int k = 0; k < nms_pkg::NODES; k++) begin
			u = -1;
			best = -1;
			for (int v = 0; v < nms_pkg::NODES; v++)
				if (!done[v] && path_len[v] >= 0 && (best < 0 || path_len[v] < best)) begin
					best = path_len[v];
					u = v;
				end
			if (u < 0) return r;
			done[u] = 1;
			if (has_beds[u]) begin
				r.found = 1'b1;
				r.node = u[nms_pkg::NODE_W-1:0];
				return r;
			end
			for (int v = 0; v < nms_pkg::NODES; v++)
				if (road_len[u][v] != 0 && !done[v])
					if (path_len[v] < 0 || best + road_len[u][v] < path_len[v])
						path_len[v] = best + road_len[u][v];
		end
		return r;
	endfunction

	assign pending = nearest_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [1:0]                      op;
		logic [nms_pkg::NODE_W-1:0]      a, b;
		logic [nms_pkg::LENGTH_BITS-1:0] len;
		nearest_t                        want, got;
		if (!arst_n) begin
			foreach (road_len[i, j]) road_len[i][j] = '0;
			foreach (has_beds[i]) has_beds[i] = 1'b0;
			nearest_q.delete();
			mismatches = 0;
			results_seen = 0;
		end else begin
			// Output side first: a result word never depends on the input word
			// accepted at the same edge.
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[6:1]};
				results_seen++;
				if (nearest_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected result word found=%0d node=%0d",
							got.found, got.node);
				end else begin
					want = nearest_q.pop_front();
					if (got.found !== want.found || got.node !== want.node) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: found exp %0d got %0d, node exp %0d got %0d",
								want.found, got.found, want.node, got.node);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				op  = s_tdata[1:0];
				a   = s_tdata[7:2];
				b   = s_tdata[13:8];
				len = s_tdata[29:14];
				case (op)
					nms_pkg::OP_ADD_EDGE: if (len != 0) begin
						if (road_len[a][b] == 0 || len < road_len[a][b]) road_len[a][b] = len;
						if (road_len[b][a] == 0 || len < road_len[b][a]) road_len[b][a] = len;
					end
					nms_pkg::OP_SET_BEDS: has_beds[a] = (s_tdata[45:30] != 0);
					nms_pkg::OP_QUERY:    nearest_q = {nearest_q, find_nearest(a)};
					default: ;
				endcase
			end
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for nearest_marked_node_search_core
// Sends directed and random edge, mark, query and unused-op words with random gaps,
// stalls the result channel at random, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         LIMIT     = 8_000_000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	int          mismatches;
	int          pending;
	int          results_seen;
	int          cycles;
	int          words_sent;

	nearest_marked_node_search_core dut (.*);

	nms_tb_checker chk (.*);

	// Clock and cycle limit.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Result channel: random stall before each word.
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n) begin
				stall = $urandom_range(0, 11);
				if ($urandom_range(0, 3) == 0) stall = 0;
				repeat (stall) @(negedge clk);
				m_tready = 1'b1;
				do @(posedge clk); while (!m_tvalid);
				@(negedge clk);
				m_tready = 1'b0;
			end
		end
	end

	// Send one word after a random gap; valid stays high until accepted.
	task automatic send_word(logic [1:0] op, logic [5:0] a, logic [5:0] b,
			logic [15:0] len, logic [15:0] beds, bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 11);
		repeat (gap) @(negedge clk);
		s_tdata  = {2'b00, beds, len, b, a, op};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		words_sent++;
	endtask

	// Random graph pieces: edges, marks, queries and rare unused op words, mostly among nodes 0 to 15.
	task automatic random_word(bit burst);
		int          pick;
		logic [5:0]  a, b;
		pick = $urandom_range(0, 99);
		a = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15));
		b = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15));
		if (pick < 45)
			send_word(nms_pkg::OP_ADD_EDGE, a, b,
				($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
				16'($urandom), burst);
		else if (pick < 65)
			send_word(nms_pkg::OP_SET_BEDS, a, b, 16'($urandom),
				($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom), burst);
		else if (pick < 97)
			send_word(nms_pkg::OP_QUERY, a, b, 16'($urandom), 16'($urandom), burst);
		else
			send_word(OP_UNUSED, a, b, 16'($urandom), 16'($urandom), burst);
	endtask

	initial begin
		int wait_cycles;
		cycles     = 0;
		words_sent = 0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty graph, source marked, ties, parallel edges, extremes.
		send_word(nms_pkg::OP_QUERY, 6'd0, 6'd0, 16'h0, 16'h0, 0);
		send_word(nms_pkg::OP_SET_BEDS, 6'd63, 6'd0, 16'h0, 16'hFFFF, 0);
		send_word(nms_pkg::OP_QUERY, 6'd63, 6'd0, 16'h0, 16'h0, 0);
		send_word(nms_pkg::OP_QUERY, 6'd0, 6'd0, 16'h0, 16'h0, 0);
		send_word(nms_pkg::OP_ADD_EDGE, 6'd0, 6'd63, 16'hFFFF, 16'hFFFF, 0);
		send_word(nms_pkg::OP_QUERY, 6'd0, 6'd0, 16'h0, 16'h0, 0);
		send_word(nms_pkg::OP_ADD_EDGE, 6'd0, 6'd5, 16'h0, 16'h0, 0);
		send_word(nms_pkg::OP_SET_BEDS, 6'd5, 6'd0, 16'h0, 16'h0001, 0);
		send_word(nms_pkg::OP_QUERY, 6'd0, 6'd0, 16'h0, 16'h0, 0);
		send_word(nms_pkg::OP_ADD_EDGE, 6'd0, 6'd5, 16'd70, 16'h0, 0);
		send_word(nms_pkg::OP_ADD_EDGE, 6'd5, 6'd0, 16'd90, 16'h0, 0);
		send_word(nms_pkg::OP_ADD_EDGE, 6'd0, 6'd3, 16'd70, 16'h0, 0);
		send_word(nms_pkg::OP_SET_BEDS, 6'd3, 6'd0, 16'h0, 16'h8000, 0);
		send_word(nms_pkg::OP_QUERY, 6'd0, 6'd0, 16'h0, 16'h0, 0);
		send_word(nms_pkg::OP_ADD_EDGE, 6'd7, 6'd7, 16'd1, 16'h0, 0);
		send_word(nms_pkg::OP_QUERY, 6'd7, 6'd0, 16'h0, 16'h0, 0);
		send_word(OP_UNUSED, 6'd0, 6'd3, 16'd1, 16'hFFFF, 0);
		send_word(nms_pkg::OP_SET_BEDS, 6'd3, 6'd0, 16'h0, 16'h0, 0);
		send_word(nms_pkg::OP_QUERY, 6'd5, 6'd0, 16'h0, 16'h0, 0);
		send_word(nms_pkg::OP_SET_BEDS, 6'd63, 6'd0, 16'h0, 16'h0, 0);

		// Hold off until all results are back.
		wait (pending == 0);

		// Random part, with back-to-back bursts now and then.
		for (int i = 0; i < 120; i++)
			random_word((i / 20) % 2 == 1);

		wait (pending == 0);
		wait_cycles = 0;
		while (wait_cycles < 9000) begin
			@(posedge clk);
			wait_cycles++;
		end

		$display("Sent %0d words of all four op codes; checked %0d query results.",
			words_sent, results_seen);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
